### rtl/lrubbc_pkg.sv
// Shared types, widths and codes for the LRU byte-budget cache directory.
// Has no dependencies; the recency cell and the top level both import it.
`timescale 1ns / 1ps

package lrubbc_pkg;

    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 32;
    localparam int TOTAL_W = 33;
    localparam int CNT_W   = 32;
    localparam int ACT_W   = 2;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 264;

    localparam logic [SIZE_W-1:0] CAP_RESET = 32'd65536;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUT    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic KIND_FINAL  = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic take_prev;   // load the neighbour's entry
        logic kill;        // drop the entry held here
    } t_cell_ctrl;

    // Saturating increment of a 32-bit counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

### rtl/lrubbc_cell.sv
// One place of the recency chain: holds a key, a byte size and a valid bit.
// Depends on lrubbc_pkg for widths and the cell control struct.
`timescale 1ns / 1ps

module lrubbc_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lrubbc_pkg::t_cell_ctrl      i_ctrl,
    input  logic                        i_prev_valid,
    input  logic [lrubbc_pkg::KEY_W-1:0]  i_prev_key,
    input  logic [lrubbc_pkg::SIZE_W-1:0] i_prev_bytes,
    input  logic [lrubbc_pkg::KEY_W-1:0]  i_key,
    output logic                        o_valid,
    output logic [lrubbc_pkg::KEY_W-1:0]  o_key,
    output logic [lrubbc_pkg::SIZE_W-1:0] o_bytes,
    output logic                        o_match
);
    import lrubbc_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [SIZE_W-1:0] r_bytes;

    // The valid bit is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.kill) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.take_prev) begin
            r_valid <= i_prev_valid;
        end
    end

    // Payload follows the neighbour when the chain shifts.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take_prev) begin
            r_key   <= i_prev_key;
            r_bytes <= i_prev_bytes;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_bytes = r_bytes;
    assign o_match = r_valid && (r_key == i_key);

endmodule

### rtl/lru_byte_budget_cache_directory.sv
// Top level of the LRU byte-budget cache directory: sequencer, counters and cell chain.
// Depends on lrubbc_pkg and lrubbc_cell.
`timescale 1ns / 1ps

// Entries sit in a chain of cells ordered by recency: cell 0 is the most recent and
// the last valid cell is the least recent, so a hit or an insert shifts the chain by
// one place towards the tail and an eviction drops the tail. A lookup, a clear or an
// unused action passes through the sequencer steps accept, key compare in every cell,
// chain update and result. A put adds a budget check and its eviction notices before
// the result; it can raise up to ENTRIES notices before its final result, which
// carries tlast. A stalled result word holds the sequencer until it is taken. No
// clearing pass is needed after reset.
module lru_byte_budget_cache_directory #(
    parameter int ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrubbc_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // key[63:0], size[95:64]
    input  logic [lrubbc_pkg::IN_W-1:0]     i_s_axis_tdata,
    // action[1:0]
    input  logic [lrubbc_pkg::ACT_W-1:0]    i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // hit[0], entry_size[32:1], stored[33], evicted_id[97:34], evicted_size[129:98],
    // total[162:130], hit_count[194:163], miss_count[226:195],
    // eviction_count[258:227], zero fill[263:259]
    output logic [lrubbc_pkg::OUT_W-1:0]    o_m_axis_tdata,
    // result_kind[0]
    output logic                            o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import lrubbc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int NUM_W = $clog2(ENTRIES + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MATCH  = 6'b000010,
        ST_APPLY  = 6'b000100,
        ST_FULLEV = 6'b001000,
        ST_EVCHK  = 6'b010000,
        ST_FINAL  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [ACT_W-1:0]  r_action, n_action;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_cap;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CNT_W-1:0]  r_hits, n_hits, r_miss, n_miss, r_evc, n_evc;
    logic [NUM_W-1:0]  r_count, n_count, r_k, n_k;
    logic [ENTRIES-1:0] r_match, n_match;
    logic              r_hit, n_hit;
    logic [SIZE_W-1:0] r_hit_bytes, n_hit_bytes;
    logic              r_res_hit, n_res_hit, r_res_stored, n_res_stored;
    logic [SIZE_W-1:0] r_res_esize, n_res_esize;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_kind, r_out_last;

    t_cell_ctrl        w_ctrl [ENTRIES];
    logic              w_valid [ENTRIES];
    logic [KEY_W-1:0]  w_key [ENTRIES];
    logic [SIZE_W-1:0] w_bytes [ENTRIES];
    logic [ENTRIES-1:0] w_match;

    logic              accept, out_free, full;
    logic [IDX_W-1:0]  tail_idx;
    logic [KEY_W-1:0]  tail_key;
    logic [SIZE_W-1:0] tail_bytes, head_bytes, sel_bytes;
    logic [ENTRIES-1:0] front_mask;
    logic              mask_acc;

    logic              emit, emit_kind, emit_hit, emit_stored;
    logic [SIZE_W-1:0] emit_esize, emit_vsize;
    logic [KEY_W-1:0]  emit_vid;
    logic [TOTAL_W-1:0] emit_total;

    // Chain of cells; the head cell is fed by the entry being made most recent.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            lrubbc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl[g]),
                .i_prev_valid (1'b1),
                .i_prev_key   (r_key),
                .i_prev_bytes (head_bytes),
                .i_key        (r_key),
                .o_valid      (w_valid[g]),
                .o_key        (w_key[g]),
                .o_bytes      (w_bytes[g]),
                .o_match      (w_match[g])
            );
        end else begin : g_body
            lrubbc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl[g]),
                .i_prev_valid (w_valid[g-1]),
                .i_prev_key   (w_key[g-1]),
                .i_prev_bytes (w_bytes[g-1]),
                .i_key        (r_key),
                .o_valid      (w_valid[g]),
                .o_key        (w_key[g]),
                .o_bytes      (w_bytes[g]),
                .o_match      (w_match[g])
            );
        end
    end

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign full            = (r_count == NUM_W'(ENTRIES));
    assign tail_idx        = IDX_W'(r_count - 1'b1);
    assign tail_key        = w_key[tail_idx];
    assign tail_bytes      = w_bytes[tail_idx];
    assign head_bytes      = (r_action == ACT_LOOKUP) ? r_hit_bytes : r_size;

    // Size of the matching cell, and the cells from the head down to the hit.
    always_comb begin
        sel_bytes = '0;
        mask_acc  = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            sel_bytes = sel_bytes | (w_match[i] ? w_bytes[i] : '0);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            mask_acc      = mask_acc | r_match[i];
            front_mask[i] = mask_acc;
        end
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_key        = r_key;
        n_size       = r_size;
        n_total      = r_total;
        n_hits       = r_hits;
        n_miss       = r_miss;
        n_evc        = r_evc;
        n_count      = r_count;
        n_k          = r_k;
        n_match      = r_match;
        n_hit        = r_hit;
        n_hit_bytes  = r_hit_bytes;
        n_res_hit    = r_res_hit;
        n_res_stored = r_res_stored;
        n_res_esize  = r_res_esize;
        emit         = 1'b0;
        emit_kind    = KIND_FINAL;
        emit_hit     = 1'b0;
        emit_stored  = 1'b0;
        emit_esize   = '0;
        emit_vid     = '0;
        emit_vsize   = '0;
        emit_total   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_ctrl[i] = '0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_action     = i_s_axis_tuser;
                    n_key        = i_s_axis_tdata[KEY_W-1:0];
                    n_size       = i_s_axis_tdata[KEY_W +: SIZE_W];
                    n_k          = '0;
                    n_res_hit    = 1'b0;
                    n_res_stored = 1'b0;
                    n_res_esize  = '0;
                    n_state      = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_match     = w_match;
                n_hit       = |w_match;
                n_hit_bytes = sel_bytes;
                n_state     = ST_APPLY;
            end
            ST_APPLY: begin
                n_state = ST_FINAL;
                unique case (r_action)
                    ACT_LOOKUP: begin
                        if (r_hit) begin
                            for (int i = 0; i < ENTRIES; i++) begin
                                w_ctrl[i].take_prev = front_mask[i];
                            end
                            n_hits      = sat_inc(r_hits);
                            n_res_hit   = 1'b1;
                            n_res_esize = r_hit_bytes;
                        end else begin
                            n_miss = sat_inc(r_miss);
                        end
                    end
                    ACT_PUT: begin
                        n_state = ST_EVCHK;
                        if (r_hit) begin
                            for (int i = 0; i < ENTRIES; i++) begin
                                w_ctrl[i].take_prev = front_mask[i];
                            end
                            n_total      = r_total - TOTAL_W'(r_hit_bytes)
                                           + TOTAL_W'(r_size);
                            n_res_hit    = 1'b1;
                            n_res_stored = 1'b1;
                        end else if (r_size <= r_cap) begin
                            if (full) begin
                                n_state = ST_FULLEV;
                            end else begin
                                for (int i = 0; i < ENTRIES; i++) begin
                                    w_ctrl[i].take_prev = 1'b1;
                                end
                                n_count      = r_count + 1'b1;
                                n_total      = r_total + TOTAL_W'(r_size);
                                n_res_stored = 1'b1;
                            end
                        end
                    end
                    ACT_CLEAR: begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            w_ctrl[i].kill = 1'b1;
                        end
                        n_count = '0;
                        n_total = '0;
                        n_hits  = '0;
                        n_miss  = '0;
                        n_evc   = '0;
                    end
                    default: begin
                        n_state = ST_FINAL;
                    end
                endcase
            end
            ST_FULLEV: begin
                // The shift pushes the least recent entry out of the tail cell. The
                // notice shows the total after the eviction, before the insert.
                if (out_free) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        w_ctrl[i].take_prev = 1'b1;
                    end
                    n_total      = r_total - TOTAL_W'(tail_bytes) + TOTAL_W'(r_size);
                    n_evc        = sat_inc(r_evc);
                    n_k          = r_k + 1'b1;
                    n_res_stored = 1'b1;
                    emit         = 1'b1;
                    emit_kind    = KIND_NOTICE;
                    emit_vid     = tail_key;
                    emit_vsize   = tail_bytes;
                    emit_total   = r_total - TOTAL_W'(tail_bytes);
                    n_state      = ST_EVCHK;
                end
            end
            ST_EVCHK: begin
                if (r_total > TOTAL_W'(r_cap) && r_k < NUM_W'(ENTRIES)
                        && r_count != '0) begin
                    if (out_free) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            w_ctrl[i].kill = (IDX_W'(i) == tail_idx);
                        end
                        n_count    = r_count - 1'b1;
                        n_total    = r_total - TOTAL_W'(tail_bytes);
                        n_evc      = sat_inc(r_evc);
                        n_k        = r_k + 1'b1;
                        emit       = 1'b1;
                        emit_kind  = KIND_NOTICE;
                        emit_vid   = tail_key;
                        emit_vsize = tail_bytes;
                        emit_total = n_total;
                    end
                end else begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_kind   = KIND_FINAL;
                    emit_hit    = r_res_hit;
                    emit_stored = r_res_stored;
                    emit_esize  = r_res_esize;
                    emit_total  = r_total;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAP_RESET;
            r_total <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_evc   <= '0;
            r_count <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_hits  <= n_hits;
            r_miss  <= n_miss;
            r_evc   <= n_evc;
            r_count <= n_count;
            r_k     <= n_k;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Item payload held through the sequence.
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_key        <= n_key;
        r_size       <= n_size;
        r_match      <= n_match;
        r_hit        <= n_hit;
        r_hit_bytes  <= n_hit_bytes;
        r_res_hit    <= n_res_hit;
        r_res_stored <= n_res_stored;
        r_res_esize  <= n_res_esize;
    end

    // Output register; a new word is loaded only when the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= emit_kind;
            r_out_last <= (emit_kind == KIND_FINAL);
            r_out_data <= {5'b0, n_evc, n_miss, n_hits, emit_total, emit_vsize, emit_vid,
                           emit_stored, emit_esize, emit_hit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

### bench/lru_byte_budget_cache_directory_chk.sv
// Checker for the LRU byte-budget cache directory: watches the input, output and
// configuration ports, predicts every result word and compares. Depends on lrubbc_pkg.
`timescale 1ns / 1ps

module lru_byte_budget_cache_directory_chk
    import lrubbc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SIZE_W-1:0]    i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [IN_W-1:0]      i_s_tdata,
    input  logic [ACT_W-1:0]     i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [OUT_W-1:0]     i_m_tdata,
    input  logic                 i_m_tuser,
    input  logic                 i_m_tlast,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_words_seen,
    output int                   o_notices_seen
);

    // One result word, as the block packs it, plus kind and last.
    typedef struct packed {
        logic              kind;
        logic              last;
        logic [OUT_W-1:0]  data;
    } t_result;

    t_result          directory_results[$];

    // Predicted directory state.
    logic [KEY_W-1:0]   dir_key   [ENTRIES];
    logic [SIZE_W-1:0]  dir_bytes [ENTRIES];
    logic               dir_valid [ENTRIES];
    int                 dir_rank  [ENTRIES];
    logic [TOTAL_W-1:0] dir_total;
    logic [CNT_W-1:0]   dir_hits, dir_misses, dir_evicts;
    logic [SIZE_W-1:0]  dir_capacity;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        count_up = (v == '1) ? v : v + 1'b1;
    endfunction

    // Pushes one result word built from the current totals and counters.
    function automatic void push_result(input logic kind, input logic hit,
                                        input logic [SIZE_W-1:0] esz,
                                        input logic stored, input logic [KEY_W-1:0] vid,
                                        input logic [SIZE_W-1:0] vsz, input logic last);
        t_result r;
        r.kind = kind;
        r.last = last;
        r.data = '0;
        r.data[0]       = hit;
        r.data[32:1]    = esz;
        r.data[33]      = stored;
        r.data[97:34]   = vid;
        r.data[129:98]  = vsz;
        r.data[162:130] = dir_total;
        r.data[194:163] = dir_hits;
        r.data[226:195] = dir_misses;
        r.data[258:227] = dir_evicts;
        directory_results.push_back(r);
    endfunction

    function automatic int find_entry(input logic [KEY_W-1:0] key);
        find_entry = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (find_entry < 0 && dir_valid[i] && dir_key[i] == key) find_entry = i;
    endfunction

    task automatic promote(input int idx);
        for (int j = 0; j < ENTRIES; j++)
            if (dir_valid[j] && dir_rank[j] < dir_rank[idx]) dir_rank[j]++;
        dir_rank[idx] = 0;
    endtask

    // Drops the least recent entry with a notice; returns 0 on an empty table.
    function automatic int evict_oldest();
        int v;
        v = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && (v < 0 || dir_rank[i] > dir_rank[v])) v = i;
        if (v < 0) return 0;
        dir_valid[v] = 1'b0;
        dir_total = dir_total - TOTAL_W'(dir_bytes[v]);
        dir_evicts = count_up(dir_evicts);
        push_result(KIND_NOTICE, 1'b0, '0, 1'b0, dir_key[v], dir_bytes[v], 1'b0);
        return 1;
    endfunction

    task automatic clear_directory();
        for (int i = 0; i < ENTRIES; i++) begin
            dir_valid[i] = 1'b0;
            dir_rank[i] = 0;
        end
        dir_total = '0;
        dir_hits = '0;
        dir_misses = '0;
        dir_evicts = '0;
    endtask

    // Works out every result word caused by one accepted input word.
    task automatic predict_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                                input logic [SIZE_W-1:0] sz);
        int idx, slot, n;
        logic hit, stored;
        hit = 1'b0;
        stored = 1'b0;
        n = 0;
        case (act)
            ACT_LOOKUP: begin
                idx = find_entry(key);
                if (idx >= 0) begin
                    promote(idx);
                    dir_hits = count_up(dir_hits);
                    push_result(KIND_FINAL, 1'b1, dir_bytes[idx], 1'b0, '0, '0, 1'b1);
                end else begin
                    dir_misses = count_up(dir_misses);
                    push_result(KIND_FINAL, 1'b0, '0, 1'b0, '0, '0, 1'b1);
                end
            end
            ACT_PUT: begin
                idx = find_entry(key);
                if (idx >= 0) begin
                    dir_total = dir_total - TOTAL_W'(dir_bytes[idx]) + TOTAL_W'(sz);
                    dir_bytes[idx] = sz;
                    promote(idx);
                    hit = 1'b1;
                    stored = 1'b1;
                end else if (sz <= dir_capacity) begin
                    slot = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !dir_valid[i]) slot = i;
                    if (slot < 0) begin
                        n += evict_oldest();
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot < 0 && !dir_valid[i]) slot = i;
                    end
                    for (int i = 0; i < ENTRIES; i++)
                        if (dir_valid[i]) dir_rank[i]++;
                    dir_valid[slot] = 1'b1;
                    dir_key[slot] = key;
                    dir_bytes[slot] = sz;
                    dir_rank[slot] = 0;
                    dir_total = dir_total + TOTAL_W'(sz);
                    stored = 1'b1;
                end
                while (dir_total > {1'b0, dir_capacity} && n < ENTRIES) begin
                    if (evict_oldest() == 0) break;
                    n++;
                end
                push_result(KIND_FINAL, hit, '0, stored, '0, '0, 1'b1);
            end
            ACT_CLEAR: begin
                clear_directory();
                push_result(KIND_FINAL, 1'b0, '0, 1'b0, '0, '0, 1'b1);
            end
            default: push_result(KIND_FINAL, 1'b0, '0, 1'b0, '0, '0, 1'b1);
        endcase
    endtask

    assign o_pending = directory_results.size();

    // Prediction on accepted input words, comparison on accepted result words.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_directory();
            dir_capacity <= CAP_RESET;
            directory_results.delete();
            o_fail_count <= 0;
            o_words_seen <= 0;
            o_notices_seen <= 0;
        end else begin
            if (i_cfg_we) dir_capacity <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                predict_word(i_s_tuser, i_s_tdata[63:0], i_s_tdata[95:64]);
            if (i_m_tvalid && i_m_tready) begin
                o_words_seen <= o_words_seen + 1;
                if (i_m_tuser == KIND_NOTICE) o_notices_seen <= o_notices_seen + 1;
                if (directory_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result word data=%h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = directory_results.pop_front();
                    if (want.data !== i_m_tdata || want.kind !== i_m_tuser
                        || want.last !== i_m_tlast) begin
                        if (o_fail_count < 10) begin
                            $display("ERROR: result word differs at %0t", $realtime);
                            $display("  expected kind=%b last=%b data=%h",
                                     want.kind, want.last, want.data);
                            $display("  actual   kind=%b last=%b data=%h",
                                     i_m_tuser, i_m_tlast, i_m_tdata);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### bench/lru_byte_budget_cache_directory_tb.sv
// Testbench top for the LRU byte-budget cache directory: drives lookups, puts and
// clears under several byte budgets. Depends on lrubbc_pkg, the block and its checker.
`timescale 1ns / 1ps

module lru_byte_budget_cache_directory_tb;
    import lrubbc_pkg::*;

    localparam int ENTRIES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [SIZE_W-1:0]  cfg_wdata;
    logic               s_tvalid, s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic [ACT_W-1:0]   s_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tuser, m_tlast;
    int                 fail_count, pending, words_seen, notices_seen;
    int                 cycles = 0;
    int                 stall_mode = 0;
    logic [KEY_W-1:0]   key_pool [8];

    lru_byte_budget_cache_directory #(.ENTRIES(ENTRIES)) u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast)
    );

    lru_byte_budget_cache_directory_chk #(.ENTRIES(ENTRIES)) u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending), .o_words_seen(words_seen),
        .o_notices_seen(notices_seen)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the cycle count.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stalls: a mode changes every so often between none, light and heavy.
    always @(posedge clk) begin
        if (($urandom % 64) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom % 4) != 0;
            default: m_tready <= ($urandom % 4) == 0;
        endcase
    end

    // Sends one word and holds it until it is taken.
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                             input logic [SIZE_W-1:0] sz);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {sz, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Waits for all results, lets the block settle, then writes the budget.
    task automatic set_budget(input logic [SIZE_W-1:0] cap);
        idle_gap(1);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random phase: mostly puts and lookups over a small key pool, in bursts.
    task automatic random_phase(input int n, input logic [SIZE_W-1:0] size_hi);
        int burst;
        int r;
        logic [KEY_W-1:0] key;
        logic [SIZE_W-1:0] sz;
        logic [ACT_W-1:0] act;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom % 3 != 0) idle_gap($urandom_range(1, 6));
            end
            burst--;
            r = $urandom % 100;
            if (r < 50) act = ACT_PUT;
            else if (r < 92) act = ACT_LOOKUP;
            else if (r < 96) act = ACT_CLEAR;
            else act = ACT_UNUSED;
            if ($urandom % 8 == 0) key = {$urandom, $urandom};
            else key = key_pool[$urandom % 8] + ($urandom % 4);
            if ($urandom % 10 == 0) sz = $urandom;
            else sz = $urandom_range(0, size_hi);
            send_word(act, key, sz);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_LOOKUP;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom} & ~64'd7;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default budget, extremes, every action, full table.
        send_word(ACT_LOOKUP, '0, '0);
        send_word(ACT_PUT, '0, 32'd100);
        send_word(ACT_PUT, '1, 32'd200);
        send_word(ACT_LOOKUP, '1, '0);
        send_word(ACT_LOOKUP, '0, '1);
        send_word(ACT_PUT, 64'h1, '1);              // larger than the budget: dropped
        send_word(ACT_PUT, '0, 32'd70000);          // update past the budget: evicts
        send_word(ACT_UNUSED, '1, '1);
        for (int i = 0; i < ENTRIES + 2; i++)       // overfills the table
            send_word(ACT_PUT, 64'h100 + i, 32'd10);
        send_word(ACT_CLEAR, '0, '0);

        // Budget at the top, several entries, then mass eviction by a put once it is lowered.
        set_budget('1);
        for (int i = 0; i < 6; i++) send_word(ACT_PUT, key_pool[i], 32'h4000_0000);
        send_word(ACT_LOOKUP, key_pool[0], '0);
        set_budget(32'd0);
        send_word(ACT_LOOKUP, key_pool[1], '0);     // lowering alone evicts nothing
        send_word(ACT_PUT, key_pool[2], 32'd0);     // this put drains the table
        set_budget(32'd1000);
        random_phase(44, 32'd300);
        set_budget(CAP_RESET);
        random_phase(44, 32'd12000);
        set_budget('1);
        random_phase(36, '1);

        idle_gap(1);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Covered %0d result words, %0d of them eviction notices, under several budgets.",
                 words_seen, notices_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
